FILE: hdl/svpwm_pkg.sv
// Package: payload types, register indexes and sine table for the SVPWM duty block.
package svpwm_pkg;

  localparam int unsigned SineRomDepth = 172;
  localparam logic [15:0] Deg60 = 16'h2AAA;

  localparam logic [1:0] RegHalfPeriod = 2'd0;
  localparam logic [1:0] RegMagLimit   = 2'd1;
  localparam logic [1:0] RegMinGap     = 2'd2;
  localparam logic [1:0] RegTrigDelay  = 2'd3;

  typedef struct packed {
    logic [15:0] magnitude;
    logic [15:0] angle;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [15:0] shifted_a;
    logic [15:0] shifted_b;
    logic [15:0] shifted_c;
    logic [15:0] compensate_a;
    logic [15:0] compensate_b;
    logic [15:0] compensate_c;
    logic [15:0] trigger_first;
    logic [15:0] trigger_second;
  } out_beat_t;

  // Sine over 0 to 60 degrees in Q15, indexed by in-sector angle >> 6.
  function automatic logic [14:0] sine_lut(input logic [9:0] idx);
    logic [14:0] v;
    unique case (idx)
      10'd0: v = 15'd0; 10'd1: v = 15'd201; 10'd2: v = 15'd401; 10'd3: v = 15'd602;
      10'd4: v = 15'd803; 10'd5: v = 15'd1003; 10'd6: v = 15'd1204; 10'd7: v = 15'd1404;
      10'd8: v = 15'd1605; 10'd9: v = 15'd1805; 10'd10: v = 15'd2005; 10'd11: v = 15'd2206;
      10'd12: v = 15'd2406; 10'd13: v = 15'd2606; 10'd14: v = 15'd2806; 10'd15: v = 15'd3006;
      10'd16: v = 15'd3205; 10'd17: v = 15'd3405; 10'd18: v = 15'd3605; 10'd19: v = 15'd3804;
      10'd20: v = 15'd4003; 10'd21: v = 15'd4202; 10'd22: v = 15'd4401; 10'd23: v = 15'd4600;
      10'd24: v = 15'd4799; 10'd25: v = 15'd4997; 10'd26: v = 15'd5195; 10'd27: v = 15'd5393;
      10'd28: v = 15'd5591; 10'd29: v = 15'd5789; 10'd30: v = 15'd5986; 10'd31: v = 15'd6183;
      10'd32: v = 15'd6380; 10'd33: v = 15'd6577; 10'd34: v = 15'd6773; 10'd35: v = 15'd6970;
      10'd36: v = 15'd7166; 10'd37: v = 15'd7361; 10'd38: v = 15'd7557; 10'd39: v = 15'd7752;
      10'd40: v = 15'd7947; 10'd41: v = 15'd8141; 10'd42: v = 15'd8335; 10'd43: v = 15'd8529;
      10'd44: v = 15'd8723; 10'd45: v = 15'd8916; 10'd46: v = 15'd9109; 10'd47: v = 15'd9302;
      10'd48: v = 15'd9494; 10'd49: v = 15'd9686; 10'd50: v = 15'd9877; 10'd51: v = 15'd10068;
      10'd52: v = 15'd10259; 10'd53: v = 15'd10449; 10'd54: v = 15'd10639; 10'd55: v = 15'd10829;
      10'd56: v = 15'd11018; 10'd57: v = 15'd11207; 10'd58: v = 15'd11395; 10'd59: v = 15'd11583;
      10'd60: v = 15'd11771; 10'd61: v = 15'd11958; 10'd62: v = 15'd12144; 10'd63: v = 15'd12331;
      10'd64: v = 15'd12516; 10'd65: v = 15'd12701; 10'd66: v = 15'd12886; 10'd67: v = 15'd13070;
      10'd68: v = 15'd13254; 10'd69: v = 15'd13437; 10'd70: v = 15'd13620; 10'd71: v = 15'd13802;
      10'd72: v = 15'd13984; 10'd73: v = 15'd14165; 10'd74: v = 15'd14346; 10'd75: v = 15'd14526;
      10'd76: v = 15'd14706; 10'd77: v = 15'd14885; 10'd78: v = 15'd15063; 10'd79: v = 15'd15241;
      10'd80: v = 15'd15419; 10'd81: v = 15'd15595; 10'd82: v = 15'd15772; 10'd83: v = 15'd15947;
      10'd84: v = 15'd16122; 10'd85: v = 15'd16297; 10'd86: v = 15'd16470; 10'd87: v = 15'd16643;
      10'd88: v = 15'd16816; 10'd89: v = 15'd16988; 10'd90: v = 15'd17159; 10'd91: v = 15'd17330;
      10'd92: v = 15'd17500; 10'd93: v = 15'd17669; 10'd94: v = 15'd17838; 10'd95: v = 15'd18006;
      10'd96: v = 15'd18173; 10'd97: v = 15'd18340; 10'd98: v = 15'd18506; 10'd99: v = 15'd18671;
      10'd100: v = 15'd18835; 10'd101: v = 15'd18999; 10'd102: v = 15'd19162;
      10'd103: v = 15'd19325; 10'd104: v = 15'd19487; 10'd105: v = 15'd19647;
      10'd106: v = 15'd19808; 10'd107: v = 15'd19967; 10'd108: v = 15'd20126;
      10'd109: v = 15'd20284; 10'd110: v = 15'd20441; 10'd111: v = 15'd20598;
      10'd112: v = 15'd20753; 10'd113: v = 15'd20908; 10'd114: v = 15'd21062;
      10'd115: v = 15'd21216; 10'd116: v = 15'd21368; 10'd117: v = 15'd21520;
      10'd118: v = 15'd21671; 10'd119: v = 15'd21821; 10'd120: v = 15'd21970;
      10'd121: v = 15'd22119; 10'd122: v = 15'd22266; 10'd123: v = 15'd22413;
      10'd124: v = 15'd22559; 10'd125: v = 15'd22704; 10'd126: v = 15'd22848;
      10'd127: v = 15'd22992; 10'd128: v = 15'd23134; 10'd129: v = 15'd23276;
      10'd130: v = 15'd23417; 10'd131: v = 15'd23557; 10'd132: v = 15'd23696;
      10'd133: v = 15'd23834; 10'd134: v = 15'd23971; 10'd135: v = 15'd24107;
      10'd136: v = 15'd24243; 10'd137: v = 15'd24377; 10'd138: v = 15'd24511;
      10'd139: v = 15'd24644; 10'd140: v = 15'd24776; 10'd141: v = 15'd24906;
      10'd142: v = 15'd25036; 10'd143: v = 15'd25165; 10'd144: v = 15'd25293;
      10'd145: v = 15'd25420; 10'd146: v = 15'd25547; 10'd147: v = 15'd25672;
      10'd148: v = 15'd25796; 10'd149: v = 15'd25919; 10'd150: v = 15'd26042;
      10'd151: v = 15'd26163; 10'd152: v = 15'd26283; 10'd153: v = 15'd26403;
      10'd154: v = 15'd26521; 10'd155: v = 15'd26638; 10'd156: v = 15'd26755;
      10'd157: v = 15'd26870; 10'd158: v = 15'd26984; 10'd159: v = 15'd27098;
      10'd160: v = 15'd27210; 10'd161: v = 15'd27321; 10'd162: v = 15'd27431;
      10'd163: v = 15'd27541; 10'd164: v = 15'd27649; 10'd165: v = 15'd27756;
      10'd166: v = 15'd27862; 10'd167: v = 15'd27967; 10'd168: v = 15'd28071;
      10'd169: v = 15'd28174; 10'd170: v = 15'd28276; 10'd171: v = 15'd28377;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/svpwm_single_shunt_duty.sv
// Top level: pipelined SVPWM duty generator with single-shunt edge shifting.
// Six register stages lie between the input beat and the output beat.
// One beat per clock when not stalled; the output stage sets the global pipeline advance.
// A stall freezes every stage; no beat is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults.
module svpwm_single_shunt_duty (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  svpwm_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output svpwm_pkg::out_beat_t out_data_o
);

  logic [15:0] half_q, gap_q, dly_q;
  logic [14:0] lim_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 16'd1200;
      lim_q  <= 15'd30583;
      gap_q  <= 16'd80;
      dly_q  <= 16'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        svpwm_pkg::RegHalfPeriod: half_q <= cfg_data_i;
        svpwm_pkg::RegMagLimit:   lim_q  <= cfg_data_i[14:0];
        svpwm_pkg::RegMinGap:     gap_q  <= cfg_data_i;
        svpwm_pkg::RegTrigDelay:  dly_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances when the output slot is free or being taken
  logic adv;
  logic [5:0] v_q;
  assign adv        = !v_q[5] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  // Stage 1: clamp, sector, in-sector angles
  logic [15:0] mag_c, base_c, a2_c, a1_c;
  logic [2:0]  sec_c;
  logic [15:0] mag1_q, a1_1_q, a2_1_q;
  logic [2:0]  sec1_q;
  always_comb begin
    mag_c = (in_data_i.magnitude > {1'b0, lim_q}) ? {1'b0, lim_q} : in_data_i.magnitude;
    priority if (in_data_i.angle < 16'h2AAA) begin
      sec_c = 3'd1; base_c = 16'h0000;
    end else if (in_data_i.angle < 16'h5555) begin
      sec_c = 3'd2; base_c = 16'h2AAA;
    end else if (in_data_i.angle < 16'h8000) begin
      sec_c = 3'd3; base_c = 16'h5555;
    end else if (in_data_i.angle < 16'hAAAA) begin
      sec_c = 3'd4; base_c = 16'h8000;
    end else if (in_data_i.angle < 16'hD555) begin
      sec_c = 3'd5; base_c = 16'hAAAA;
    end else begin
      sec_c = 3'd6; base_c = 16'hD555;
    end
    a2_c = in_data_i.angle - base_c;
    a1_c = svpwm_pkg::Deg60 - a2_c;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag1_q <= mag_c; sec1_q <= sec_c; a1_1_q <= a1_c; a2_1_q <= a2_c;
    end
  end

  // Stage 2: scale magnitude, look up sines
  logic [31:0] scl_prod;
  logic [15:0] scl2_q;
  logic [14:0] s1_2_q, s2_2_q;
  logic [2:0]  sec2_q;
  assign scl_prod = half_q * mag1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      scl2_q <= scl_prod[30:15];
      s1_2_q <= svpwm_pkg::sine_lut(a1_1_q[15:6]);
      s2_2_q <= svpwm_pkg::sine_lut(a2_1_q[15:6]);
      sec2_q <= sec1_q;
    end
  end

  // Stage 3: active times
  logic [30:0] t1_prod, t2_prod;
  logic [15:0] t1_3_q, t2_3_q;
  logic [2:0]  sec3_q;
  assign t1_prod = s1_2_q * scl2_q;
  assign t2_prod = s2_2_q * scl2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_3_q <= t1_prod[30:15]; t2_3_q <= t2_prod[30:15]; sec3_q <= sec2_q;
    end
  end

  // Stage 4: zero time split and phase duties by rank
  logic [17:0] diff_c;
  logic [15:0] h0_c, hi_c, mid_c;
  logic [15:0] hi4_q, mid4_q, lo4_q;
  logic [2:0]  sec4_q;
  always_comb begin
    diff_c = {2'b00, half_q} - {2'b00, t1_3_q} - {2'b00, t2_3_q};
    h0_c   = diff_c[17] ? 16'd0 : diff_c[16:1];
    hi_c   = t1_3_q + t2_3_q + h0_c;
    mid_c  = (sec3_q[0] ? t2_3_q : t1_3_q) + h0_c;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hi4_q <= hi_c; mid4_q <= mid_c; lo4_q <= h0_c; sec4_q <= sec3_q;
    end
  end

  // Stage 5: shift middle phase
  logic [15:0] lim_a, mmod_c, mnext_c, lim_b;
  logic [17:0] mc_c;
  logic [15:0] mmod5_q, mnext5_q, lim5_q, hi5_q, mid5_q, lo5_q;
  logic [2:0]  sec5_q;
  always_comb begin
    lim_a = (hi4_q > gap_q) ? hi4_q - gap_q : gap_q;
    mc_c  = {1'b0, mid4_q, 1'b0} - {2'b00, lim_a};
    if (mid4_q > lim_a) begin
      mmod_c  = lim_a;
      mnext_c = (mc_c > {2'b00, half_q}) ? half_q : mc_c[15:0];
    end else begin
      mmod_c  = mid4_q;
      mnext_c = mid4_q;
    end
    lim_b = (mmod_c > gap_q) ? mmod_c - gap_q : lim_a;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mmod5_q <= mmod_c; mnext5_q <= mnext_c; lim5_q <= lim_b;
      hi5_q <= hi4_q; mid5_q <= mid4_q; lo5_q <= lo4_q; sec5_q <= sec4_q;
    end
  end

  // Stage 6: shift lowest phase, map ranks to phases, triggers
  logic [15:0] lmod_c, lnext_c;
  logic [17:0] lc_c;
  svpwm_pkg::out_beat_t o_c, out_q;
  always_comb begin
    lc_c = {1'b0, lo5_q, 1'b0} - {2'b00, lim5_q};
    if (lo5_q > lim5_q) begin
      lmod_c  = lim5_q;
      lnext_c = (lc_c > {2'b00, half_q}) ? half_q : lc_c[15:0];
    end else begin
      lmod_c  = lo5_q;
      lnext_c = lo5_q;
    end
    o_c.sector         = sec5_q;
    o_c.trigger_first  = mmod5_q - dly_q;
    o_c.trigger_second = lmod_c - dly_q;
    unique case (sec5_q)
      3'd2: begin
        o_c.duty_a = mid5_q; o_c.duty_b = hi5_q; o_c.duty_c = lo5_q;
        o_c.shifted_a = mmod5_q; o_c.shifted_b = hi5_q; o_c.shifted_c = lmod_c;
        o_c.compensate_a = mnext5_q; o_c.compensate_b = hi5_q; o_c.compensate_c = lnext_c;
      end
      3'd3: begin
        o_c.duty_a = lo5_q; o_c.duty_b = hi5_q; o_c.duty_c = mid5_q;
        o_c.shifted_a = lmod_c; o_c.shifted_b = hi5_q; o_c.shifted_c = mmod5_q;
        o_c.compensate_a = lnext_c; o_c.compensate_b = hi5_q; o_c.compensate_c = mnext5_q;
      end
      3'd4: begin
        o_c.duty_a = lo5_q; o_c.duty_b = mid5_q; o_c.duty_c = hi5_q;
        o_c.shifted_a = lmod_c; o_c.shifted_b = mmod5_q; o_c.shifted_c = hi5_q;
        o_c.compensate_a = lnext_c; o_c.compensate_b = mnext5_q; o_c.compensate_c = hi5_q;
      end
      3'd5: begin
        o_c.duty_a = mid5_q; o_c.duty_b = lo5_q; o_c.duty_c = hi5_q;
        o_c.shifted_a = mmod5_q; o_c.shifted_b = lmod_c; o_c.shifted_c = hi5_q;
        o_c.compensate_a = mnext5_q; o_c.compensate_b = lnext_c; o_c.compensate_c = hi5_q;
      end
      3'd6: begin
        o_c.duty_a = hi5_q; o_c.duty_b = lo5_q; o_c.duty_c = mid5_q;
        o_c.shifted_a = hi5_q; o_c.shifted_b = lmod_c; o_c.shifted_c = mmod5_q;
        o_c.compensate_a = hi5_q; o_c.compensate_b = lnext_c; o_c.compensate_c = mnext5_q;
      end
      default: begin
        o_c.duty_a = hi5_q; o_c.duty_b = mid5_q; o_c.duty_c = lo5_q;
        o_c.shifted_a = hi5_q; o_c.shifted_b = mmod5_q; o_c.shifted_c = lmod_c;
        o_c.compensate_a = hi5_q; o_c.compensate_b = mnext5_q; o_c.compensate_c = lnext_c;
      end
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= o_c;
    end
  end

  assign out_valid_o = v_q[5];
  assign out_data_o  = out_q;

endmodule
